/* rtl/sql_token_scanner_core_defines.svh */
// Assertion macros shared by the scanner RTL.
`ifndef SQL_TOKEN_SCANNER_CORE_DEFINES_SVH
`define SQL_TOKEN_SCANNER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define STSC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scanner assertion failed");
`define STSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scanner assertion failed");
`else
`define STSC_ASSERT_NOW(label, clk, rst, ante, cons)
`define STSC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/stsc_pkg.sv */
package stsc_pkg;

   localparam int BYTE_W  = 8;
   localparam int KIND_W  = 6;
   localparam int INDEX_W = 5;
   localparam int NUM_KW  = 19;
   localparam int KW_MAX  = 7;

   localparam logic [KIND_W-1:0] KIND_END     = 6'd0;
   localparam logic [KIND_W-1:0] KIND_IDENT   = 6'd1;
   localparam logic [KIND_W-1:0] KIND_NUMBER  = 6'd2;
   localparam logic [KIND_W-1:0] KIND_STRING  = 6'd3;
   localparam logic [KIND_W-1:0] KIND_COMMA   = 6'd4;
   localparam logic [KIND_W-1:0] KIND_STAR    = 6'd5;
   localparam logic [KIND_W-1:0] KIND_LPAREN  = 6'd6;
   localparam logic [KIND_W-1:0] KIND_RPAREN  = 6'd7;
   localparam logic [KIND_W-1:0] KIND_EQ      = 6'd8;
   localparam logic [KIND_W-1:0] KIND_NE      = 6'd9;
   localparam logic [KIND_W-1:0] KIND_LT      = 6'd10;
   localparam logic [KIND_W-1:0] KIND_LE      = 6'd11;
   localparam logic [KIND_W-1:0] KIND_GT      = 6'd12;
   localparam logic [KIND_W-1:0] KIND_GE      = 6'd13;
   localparam logic [KIND_W-1:0] KIND_KW0     = 6'd14;
   localparam logic [KIND_W-1:0] KIND_ILLEGAL = 6'd33;

   localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
   localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
   localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [BYTE_W-1:0] CH_BANG   = 8'h21;
   localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
   localparam logic [BYTE_W-1:0] CH_SQUOTE = 8'h27;
   localparam logic [BYTE_W-1:0] CH_LPAREN = 8'h28;
   localparam logic [BYTE_W-1:0] CH_RPAREN = 8'h29;
   localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
   localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
   localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;
   localparam logic [BYTE_W-1:0] CH_LT     = 8'h3C;
   localparam logic [BYTE_W-1:0] CH_EQ     = 8'h3D;
   localparam logic [BYTE_W-1:0] CH_GT     = 8'h3E;

   // Keywords are left-aligned and padded with spaces to seven characters.
   localparam logic [BYTE_W*KW_MAX-1:0] KW_TEXT [NUM_KW] = '{
      "SELECT ", "FROM   ", "WHERE  ", "INSERT ", "INTO   ", "UPDATE ", "SET    ",
      "DELETE ", "IN     ", "BETWEEN", "AND    ", "OR     ", "NOT    ", "IS     ",
      "NULL   ", "AS     ", "CREATE ", "TABLE  ", "USE    "
   };
   localparam logic [2:0] KW_LEN [NUM_KW] = '{
      3'd6, 3'd4, 3'd5, 3'd6, 3'd4, 3'd6, 3'd3, 3'd6, 3'd2, 3'd7,
      3'd3, 3'd2, 3'd3, 3'd2, 3'd4, 3'd2, 3'd6, 3'd5, 3'd3
   };

   typedef enum logic [2:0] {
      MODE_IDLE, MODE_IDENT, MODE_NUMBER, MODE_STRING,
      MODE_MINUS, MODE_BANG, MODE_LT, MODE_GT
   } mode_type;

   typedef enum logic [2:0] {
      ST_SCAN, ST_READ, ST_STORED, ST_LIT, ST_TAIL
   } state_type;

   typedef enum logic [1:0] {RUN_NONE, RUN_STORED, RUN_LIT} run_type;
   typedef enum logic [1:0] {TAIL_NONE, TAIL_ONE, TAIL_END} tail_type;
   typedef enum logic [1:0] {OUT_STORED, OUT_LIT, OUT_TAIL} out_sel_type;

   typedef struct packed {
      logic        use_held;
      logic        latch;
      logic        commit;
      logic        run_clear;
      logic        run_step;
      logic        mem_read;
      logic        load;
      out_sel_type out_sel;
   } cmd_type;

   typedef struct packed {
      run_type  run;
      tail_type tail;
      logic     run_last;
      logic     slot_free;
   } status_type;

   function automatic logic is_digit(input logic [BYTE_W-1:0] b);
      return b inside {["0":"9"]};
   endfunction

   function automatic logic is_word(input logic [BYTE_W-1:0] b);
      return b inside {["0":"9"], ["A":"Z"], ["a":"z"], "_", "."};
   endfunction

   function automatic logic [BYTE_W-1:0] to_upper(input logic [BYTE_W-1:0] b);
      return (b inside {["a":"z"]}) ? b - 8'd32 : b;
   endfunction

   function automatic logic [NUM_KW-1:0] kw_hit(input logic [2:0] pos,
                                                input logic [BYTE_W-1:0] b);
      logic [NUM_KW-1:0] hit;
      logic [BYTE_W-1:0] up;
      up = to_upper(b);
      for (int k = 0; k < NUM_KW; k++) begin
         hit[k] = (pos < KW_LEN[k]) &&
                  (KW_TEXT[k][BYTE_W*(KW_MAX-1-int'(pos)) +: BYTE_W] == up);
      end
      return hit;
   endfunction

endpackage

/* rtl/stsc_if.sv */
interface stsc_req_if;
   logic                          valid;
   logic                          ready;
   logic [stsc_pkg::BYTE_W-1:0]   in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

interface stsc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [stsc_pkg::KIND_W-1:0]   token_kind;
   logic [stsc_pkg::BYTE_W-1:0]   text_char;
   logic [stsc_pkg::INDEX_W-1:0]  char_index;
   logic                          text_empty;
   logic                          token_last;

   modport source (output valid, output token_kind, output text_char, output char_index,
                   output text_empty, output token_last, input ready);
   modport sink (input valid, input token_kind, input text_char, input char_index,
                 input text_empty, input token_last, output ready);
endinterface

/* rtl/stsc_ctrl.sv */
`include "sql_token_scanner_core_defines.svh"

module stsc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  stsc_pkg::status_type status,
   output stsc_pkg::cmd_type    cmd
);

   stsc_pkg::state_type state_ff;
   stsc_pkg::state_type state_in;
   logic                has_output;

   assign has_output = (status.run != stsc_pkg::RUN_NONE) ||
                       (status.tail != stsc_pkg::TAIL_NONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stsc_pkg::ST_SCAN;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         stsc_pkg::ST_SCAN: begin
            if (req_valid && has_output) begin
               case (status.run)
                  stsc_pkg::RUN_STORED: state_in = stsc_pkg::ST_READ;
                  stsc_pkg::RUN_LIT:    state_in = stsc_pkg::ST_LIT;
                  default:              state_in = stsc_pkg::ST_TAIL;
               endcase
            end
         end
         stsc_pkg::ST_READ: begin
            state_in = stsc_pkg::ST_STORED;
         end
         stsc_pkg::ST_STORED: begin
            if (status.slot_free) begin
               if (!status.run_last) begin
                  state_in = stsc_pkg::ST_READ;
               end else if (status.tail != stsc_pkg::TAIL_NONE) begin
                  state_in = stsc_pkg::ST_TAIL;
               end else begin
                  state_in = stsc_pkg::ST_SCAN;
               end
            end
         end
         stsc_pkg::ST_LIT: begin
            if (status.slot_free && status.run_last) begin
               if (status.tail != stsc_pkg::TAIL_NONE) begin
                  state_in = stsc_pkg::ST_TAIL;
               end else begin
                  state_in = stsc_pkg::ST_SCAN;
               end
            end
         end
         stsc_pkg::ST_TAIL: begin
            if (status.slot_free) begin
               state_in = stsc_pkg::ST_SCAN;
            end
         end
         default: state_in = stsc_pkg::ST_SCAN;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         stsc_pkg::ST_SCAN: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (has_output) begin
                  cmd.latch     = 1'b1;
                  cmd.run_clear = 1'b1;
               end else begin
                  cmd.commit = 1'b1;
               end
            end
         end
         stsc_pkg::ST_READ: begin
            cmd.use_held = 1'b1;
            cmd.mem_read = 1'b1;
         end
         stsc_pkg::ST_STORED: begin
            cmd.use_held = 1'b1;
            cmd.out_sel  = stsc_pkg::OUT_STORED;
            if (status.slot_free) begin
               cmd.load = 1'b1;
               if (!status.run_last) begin
                  cmd.run_step = 1'b1;
               end else if (status.tail == stsc_pkg::TAIL_NONE) begin
                  cmd.commit = 1'b1;
               end
            end
         end
         stsc_pkg::ST_LIT: begin
            cmd.use_held = 1'b1;
            cmd.out_sel  = stsc_pkg::OUT_LIT;
            if (status.slot_free) begin
               cmd.load = 1'b1;
               if (!status.run_last) begin
                  cmd.run_step = 1'b1;
               end else if (status.tail == stsc_pkg::TAIL_NONE) begin
                  cmd.commit = 1'b1;
               end
            end
         end
         stsc_pkg::ST_TAIL: begin
            cmd.use_held = 1'b1;
            cmd.out_sel  = stsc_pkg::OUT_TAIL;
            if (status.slot_free) begin
               cmd.load   = 1'b1;
               cmd.commit = 1'b1;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   `STSC_ASSERT_NEXT(a_commit_returns_to_scan, clock, reset, cmd.commit, state_ff == stsc_pkg::ST_SCAN)
   `STSC_ASSERT_NOW(a_load_has_room, clock, reset, cmd.load, status.slot_free)

endmodule

/* rtl/stsc_datapath.sv */
`include "sql_token_scanner_core_defines.svh"

module stsc_datapath #(
   parameter int TEXT_CAP = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  stsc_pkg::cmd_type               cmd,
   output stsc_pkg::status_type            status,
   input  logic [stsc_pkg::BYTE_W-1:0]     in_byte,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic [stsc_pkg::KIND_W-1:0]     rsp_token_kind,
   output logic [stsc_pkg::BYTE_W-1:0]     rsp_text_char,
   output logic [stsc_pkg::INDEX_W-1:0]    rsp_char_index,
   output logic                            rsp_text_empty,
   output logic                            rsp_token_last
);

   localparam int DEPTH = TEXT_CAP - 1;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(TEXT_CAP);
   localparam int KW    = stsc_pkg::KIND_W;
   localparam int IW    = stsc_pkg::INDEX_W;
   localparam int NK    = stsc_pkg::NUM_KW;
   localparam logic [CW-1:0] COUNT_MAX   = CW'(DEPTH);
   localparam logic [CW-1:0] SHORT_LIMIT = CW'(stsc_pkg::KW_MAX + 1);

   stsc_pkg::mode_type    mode_ff;
   stsc_pkg::mode_type    mode_in;
   logic                  quote_ff;
   logic                  quote_in;
   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         count_in;
   logic [NK-1:0]         mask_ff;
   logic [NK-1:0]         mask_in;
   logic [CW-1:0]         ctr_ff;
   logic [7:0]            held_ff;
   logic [7:0]            mem_q_ff;
   logic [7:0]            text_mem [DEPTH];

   logic                  rsp_valid_ff;
   logic [KW-1:0]         rsp_kind_ff;
   logic [7:0]            rsp_char_ff;
   logic [IW-1:0]         rsp_index_ff;
   logic                  rsp_empty_ff;
   logic                  rsp_last_ff;

   logic [7:0]            b;
   logic [KW-1:0]         word_kind;

   stsc_pkg::mode_type    idle_mode;
   stsc_pkg::tail_type    idle_tail;
   logic [KW-1:0]         idle_kind;
   logic                  idle_start;
   logic                  idle_str;
   logic                  idle_minus;

   stsc_pkg::run_type     run;
   stsc_pkg::tail_type    tail;
   logic [KW-1:0]         run_kind;
   logic [KW-1:0]         tail_kind;
   logic [7:0]            lit_a;
   logic [7:0]            lit_b;
   logic [1:0]            lit_len;
   logic                  append;
   logic                  take_idle;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [7:0]            wr_data;
   logic                  run_last;
   logic                  slot_free;

   logic [KW-1:0]         load_kind;
   logic [7:0]            load_char;
   logic [IW-1:0]         load_index;
   logic                  load_empty;
   logic                  load_last;

   assign b = cmd.use_held ? held_ff : in_byte;

   always_comb begin
      word_kind = stsc_pkg::KIND_IDENT;
      for (int k = 0; k < NK; k++) begin
         if (mask_ff[k] && (count_ff < SHORT_LIMIT) &&
             (stsc_pkg::KW_LEN[k] == count_ff[2:0])) begin
            word_kind = stsc_pkg::KIND_KW0 + KW'(k);
         end
      end
   end

   // Byte seen between tokens.
   always_comb begin
      idle_mode  = stsc_pkg::MODE_IDLE;
      idle_tail  = stsc_pkg::TAIL_NONE;
      idle_kind  = stsc_pkg::KIND_ILLEGAL;
      idle_start = 1'b0;
      idle_str   = 1'b0;
      idle_minus = 1'b0;
      case (b)
         stsc_pkg::CH_SPACE, stsc_pkg::CH_TAB, stsc_pkg::CH_LF, stsc_pkg::CH_CR: begin
            idle_mode = stsc_pkg::MODE_IDLE;
         end
         stsc_pkg::CH_NUL: begin
            idle_tail = stsc_pkg::TAIL_END;
            idle_kind = stsc_pkg::KIND_END;
         end
         stsc_pkg::CH_COMMA: begin
            idle_tail = stsc_pkg::TAIL_ONE;
            idle_kind = stsc_pkg::KIND_COMMA;
         end
         stsc_pkg::CH_STAR: begin
            idle_tail = stsc_pkg::TAIL_ONE;
            idle_kind = stsc_pkg::KIND_STAR;
         end
         stsc_pkg::CH_LPAREN: begin
            idle_tail = stsc_pkg::TAIL_ONE;
            idle_kind = stsc_pkg::KIND_LPAREN;
         end
         stsc_pkg::CH_RPAREN: begin
            idle_tail = stsc_pkg::TAIL_ONE;
            idle_kind = stsc_pkg::KIND_RPAREN;
         end
         stsc_pkg::CH_EQ: begin
            idle_tail = stsc_pkg::TAIL_ONE;
            idle_kind = stsc_pkg::KIND_EQ;
         end
         stsc_pkg::CH_BANG: begin
            idle_mode = stsc_pkg::MODE_BANG;
         end
         stsc_pkg::CH_LT: begin
            idle_mode = stsc_pkg::MODE_LT;
         end
         stsc_pkg::CH_GT: begin
            idle_mode = stsc_pkg::MODE_GT;
         end
         stsc_pkg::CH_MINUS: begin
            idle_mode  = stsc_pkg::MODE_MINUS;
            idle_minus = 1'b1;
         end
         stsc_pkg::CH_SQUOTE, stsc_pkg::CH_DQUOTE: begin
            idle_mode = stsc_pkg::MODE_STRING;
            idle_str  = 1'b1;
         end
         default: begin
            if (stsc_pkg::is_digit(b)) begin
               idle_mode  = stsc_pkg::MODE_NUMBER;
               idle_start = 1'b1;
            end else if (stsc_pkg::is_word(b)) begin
               idle_mode  = stsc_pkg::MODE_IDENT;
               idle_start = 1'b1;
            end else begin
               idle_tail = stsc_pkg::TAIL_ONE;
               idle_kind = stsc_pkg::KIND_ILLEGAL;
            end
         end
      endcase
   end

   always_comb begin
      run       = stsc_pkg::RUN_NONE;
      run_kind  = stsc_pkg::KIND_ILLEGAL;
      lit_a     = b;
      lit_b     = b;
      lit_len   = 2'd0;
      tail      = stsc_pkg::TAIL_NONE;
      tail_kind = stsc_pkg::KIND_END;
      mode_in   = mode_ff;
      quote_in  = quote_ff;
      count_in  = count_ff;
      mask_in   = mask_ff;
      wr_en     = 1'b0;
      wr_addr   = count_ff[AW-1:0];
      wr_data   = b;
      append    = 1'b0;
      take_idle = 1'b0;

      case (mode_ff)
         stsc_pkg::MODE_IDENT: begin
            if (stsc_pkg::is_word(b)) begin
               append = 1'b1;
            end else begin
               run       = stsc_pkg::RUN_STORED;
               run_kind  = word_kind;
               take_idle = 1'b1;
            end
         end
         stsc_pkg::MODE_NUMBER: begin
            if (stsc_pkg::is_digit(b)) begin
               append = 1'b1;
            end else begin
               run       = stsc_pkg::RUN_STORED;
               run_kind  = stsc_pkg::KIND_NUMBER;
               take_idle = 1'b1;
            end
         end
         stsc_pkg::MODE_STRING: begin
            if (b == stsc_pkg::CH_NUL) begin
               run       = stsc_pkg::RUN_STORED;
               run_kind  = stsc_pkg::KIND_STRING;
               tail      = stsc_pkg::TAIL_END;
               tail_kind = stsc_pkg::KIND_END;
               mode_in   = stsc_pkg::MODE_IDLE;
               count_in  = '0;
            end else if (b == (quote_ff ? stsc_pkg::CH_DQUOTE : stsc_pkg::CH_SQUOTE)) begin
               run      = stsc_pkg::RUN_STORED;
               run_kind = stsc_pkg::KIND_STRING;
               mode_in  = stsc_pkg::MODE_IDLE;
               count_in = '0;
            end else begin
               append = 1'b1;
            end
         end
         stsc_pkg::MODE_MINUS: begin
            // The minus sign already sits in the first text entry.
            if (stsc_pkg::is_digit(b)) begin
               wr_en    = 1'b1;
               wr_addr  = AW'(1);
               count_in = CW'(2);
               mode_in  = stsc_pkg::MODE_NUMBER;
            end else begin
               run       = stsc_pkg::RUN_LIT;
               run_kind  = stsc_pkg::KIND_ILLEGAL;
               lit_a     = stsc_pkg::CH_MINUS;
               lit_len   = 2'd1;
               take_idle = 1'b1;
            end
         end
         stsc_pkg::MODE_BANG: begin
            run   = stsc_pkg::RUN_LIT;
            lit_a = stsc_pkg::CH_BANG;
            if (b == stsc_pkg::CH_EQ) begin
               run_kind = stsc_pkg::KIND_NE;
               lit_len  = 2'd2;
               mode_in  = stsc_pkg::MODE_IDLE;
            end else begin
               run_kind  = stsc_pkg::KIND_ILLEGAL;
               lit_len   = 2'd1;
               take_idle = 1'b1;
            end
         end
         stsc_pkg::MODE_LT: begin
            run   = stsc_pkg::RUN_LIT;
            lit_a = stsc_pkg::CH_LT;
            if (b == stsc_pkg::CH_EQ) begin
               run_kind = stsc_pkg::KIND_LE;
               lit_len  = 2'd2;
               mode_in  = stsc_pkg::MODE_IDLE;
            end else begin
               run_kind  = stsc_pkg::KIND_LT;
               lit_len   = 2'd1;
               take_idle = 1'b1;
            end
         end
         stsc_pkg::MODE_GT: begin
            run   = stsc_pkg::RUN_LIT;
            lit_a = stsc_pkg::CH_GT;
            if (b == stsc_pkg::CH_EQ) begin
               run_kind = stsc_pkg::KIND_GE;
               lit_len  = 2'd2;
               mode_in  = stsc_pkg::MODE_IDLE;
            end else begin
               run_kind  = stsc_pkg::KIND_GT;
               lit_len   = 2'd1;
               take_idle = 1'b1;
            end
         end
         default: begin
            take_idle = 1'b1;
         end
      endcase

      if (append) begin
         if (count_ff < COUNT_MAX) begin
            wr_en    = 1'b1;
            count_in = count_ff + CW'(1);
         end
         mask_in = mask_ff & stsc_pkg::kw_hit(count_ff[2:0], b) &
                   {NK{count_ff < SHORT_LIMIT}};
      end

      if (take_idle) begin
         mode_in   = idle_mode;
         tail      = idle_tail;
         tail_kind = idle_kind;
         count_in  = '0;
         if (idle_start) begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            count_in = CW'(1);
            mask_in  = stsc_pkg::kw_hit(3'd0, b);
         end
         if (idle_minus) begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = stsc_pkg::CH_MINUS;
         end
         if (idle_str) begin
            quote_in = (b == stsc_pkg::CH_DQUOTE);
         end
      end

      // A string with no text gives one empty result.
      if ((run == stsc_pkg::RUN_STORED) && (count_ff == '0)) begin
         run     = stsc_pkg::RUN_LIT;
         lit_len = 2'd0;
      end
   end

   always_comb begin
      if (run == stsc_pkg::RUN_STORED) begin
         run_last = (ctr_ff + CW'(1)) == count_ff;
      end else begin
         run_last = (lit_len == 2'd0) || ((ctr_ff + CW'(1)) == CW'(lit_len));
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      status.run       = run;
      status.tail      = tail;
      status.run_last  = run_last;
      status.slot_free = slot_free;
   end

   always_comb begin
      case (cmd.out_sel)
         stsc_pkg::OUT_STORED: begin
            load_kind  = run_kind;
            load_char  = mem_q_ff;
            load_index = IW'(ctr_ff);
            load_empty = 1'b0;
            load_last  = run_last;
         end
         stsc_pkg::OUT_LIT: begin
            load_kind  = run_kind;
            load_char  = (lit_len == 2'd0) ? stsc_pkg::CH_NUL :
                         ((ctr_ff == '0) ? lit_a : lit_b);
            load_index = IW'(ctr_ff);
            load_empty = (lit_len == 2'd0);
            load_last  = run_last;
         end
         default: begin
            load_kind  = tail_kind;
            load_char  = (tail == stsc_pkg::TAIL_END) ? stsc_pkg::CH_NUL : b;
            load_index = '0;
            load_empty = (tail == stsc_pkg::TAIL_END);
            load_last  = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= stsc_pkg::MODE_IDLE;
         quote_ff     <= 1'b0;
         count_ff     <= '0;
         mask_ff      <= '0;
         ctr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            mode_ff  <= mode_in;
            quote_ff <= quote_in;
            count_ff <= count_in;
            mask_ff  <= mask_in;
         end
         if (cmd.run_clear) begin
            ctr_ff <= '0;
         end else if (cmd.run_step) begin
            ctr_ff <= ctr_ff + CW'(1);
         end
         if (cmd.load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         held_ff <= in_byte;
      end
      if (cmd.commit && wr_en) begin
         text_mem[wr_addr] <= wr_data;
      end
      if (cmd.mem_read) begin
         mem_q_ff <= text_mem[ctr_ff[AW-1:0]];
      end
      if (cmd.load) begin
         rsp_kind_ff  <= load_kind;
         rsp_char_ff  <= load_char;
         rsp_index_ff <= load_index;
         rsp_empty_ff <= load_empty;
         rsp_last_ff  <= load_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_token_kind = rsp_kind_ff;
   assign rsp_text_char  = rsp_char_ff;
   assign rsp_char_index = rsp_index_ff;
   assign rsp_text_empty = rsp_empty_ff;
   assign rsp_token_last = rsp_last_ff;

   `STSC_ASSERT_NOW(a_no_overwrite, clock, reset, cmd.load && rsp_valid_ff, rsp_ready)
   `STSC_ASSERT_NOW(a_empty_is_last, clock, reset, rsp_valid_ff && rsp_empty_ff, rsp_last_ff)
   `STSC_ASSERT_NOW(a_count_in_range, clock, reset, 1'b1, count_ff <= COUNT_MAX)
   `STSC_ASSERT_NOW(a_idle_no_text, clock, reset, mode_ff == stsc_pkg::MODE_IDLE, count_ff == '0)

endmodule

/* rtl/sql_token_scanner_core.sv */
// Channel    Direction  Payload                                                  Transfer
// req_chan   in         in_byte                                                  valid && ready
// rsp_chan   out        token_kind, text_char, char_index, text_empty, token_last valid && ready
//
// A byte that does not finish a token is taken back to back. A byte that finishes a token is
// taken and held; each stored text byte is then replayed by a text memory read, then an output
// register load, and each other result by an output register load alone.
// Synchronous reset clears the scanner mode, counters and output valid; the text memory is not
// cleared and only entries written for the current token are read.
// A stalled result channel holds the replay; a new byte is taken while the last result waits.

module sql_token_scanner_core #(
   parameter int TEXT_CAP = 32
) (
   input  logic        clock,
   input  logic        reset,
   stsc_req_if.sink    req_chan,
   stsc_rsp_if.source  rsp_chan
);

   stsc_pkg::cmd_type    cmd;
   stsc_pkg::status_type status;

   stsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   stsc_datapath #(
      .TEXT_CAP (TEXT_CAP)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .in_byte        (req_chan.in_byte),
      .rsp_ready      (rsp_chan.ready),
      .rsp_valid      (rsp_chan.valid),
      .rsp_token_kind (rsp_chan.token_kind),
      .rsp_text_char  (rsp_chan.text_char),
      .rsp_char_index (rsp_chan.char_index),
      .rsp_text_empty (rsp_chan.text_empty),
      .rsp_token_last (rsp_chan.token_last)
   );

endmodule

/* tb/tb_sql_token_scanner_core.sv */
`timescale 1ns / 1ps

module tb_sql_token_scanner_core;
   import stsc_pkg::*;

   localparam int TEXT_CAP    = 32;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE      = 4 * TEXT_CAP;
   localparam int PROBE_N     = 25;
   localparam int LONG_HOLD   = 300;
   localparam int PHASE_BYTES = 22;
   localparam int MAX_LINES   = 40;

   typedef logic [BYTE_W-1:0] byte_t;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      byte_t              ch;
      logic [INDEX_W-1:0] idx;
      logic               empty;
      logic               last;
   } beat_t;

   typedef struct packed {
      byte_t             b;
      logic              typed;
      logic [KIND_W-1:0] kind;
   } probe_t;

   string kw_names [NUM_KW] = '{
      "SELECT", "FROM", "WHERE", "INSERT", "INTO", "UPDATE", "SET", "DELETE", "IN",
      "BETWEEN", "AND", "OR", "NOT", "IS", "NULL", "AS", "CREATE", "TABLE", "USE"
   };

   // Rows with typed set carry a single-result token whose kind is given here.
   probe_t probe_rows [PROBE_N] = '{
      '{CH_NUL,    1'b1, KIND_END},
      '{8'hFF,     1'b1, KIND_ILLEGAL},
      '{8'h80,     1'b1, KIND_ILLEGAL},
      '{CH_COMMA,  1'b1, KIND_COMMA},
      '{CH_STAR,   1'b1, KIND_STAR},
      '{CH_LPAREN, 1'b1, KIND_LPAREN},
      '{CH_EQ,     1'b1, KIND_EQ},
      '{CH_BANG,   1'b0, KIND_END},
      '{CH_EQ,     1'b0, KIND_END},
      '{CH_LT,     1'b0, KIND_END},
      '{CH_SPACE,  1'b0, KIND_END},
      '{CH_GT,     1'b0, KIND_END},
      '{CH_EQ,     1'b0, KIND_END},
      '{CH_MINUS,  1'b0, KIND_END},
      '{"7",       1'b0, KIND_END},
      '{CH_RPAREN, 1'b0, KIND_END},
      '{CH_BANG,   1'b0, KIND_END},
      '{"i",       1'b0, KIND_END},
      '{"N",       1'b0, KIND_END},
      '{CH_DQUOTE, 1'b0, KIND_END},
      '{"a",       1'b0, KIND_END},
      '{CH_NUL,    1'b0, KIND_END},
      '{CH_MINUS,  1'b0, KIND_END},
      '{CH_SQUOTE, 1'b0, KIND_END},
      '{CH_SQUOTE, 1'b0, KIND_END}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   stsc_req_if req_if ();
   stsc_rsp_if rsp_if ();

   sql_token_scanner_core #(
      .TEXT_CAP(TEXT_CAP)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   mode_type          lex_mode = MODE_IDLE;
   logic              lex_dq = 1'b0;
   byte_t             lex_text [TEXT_CAP-1];
   int                lex_len = 0;
   beat_t             lex_out [$];
   beat_t             beats_due [$];

   logic              drive_typed = 1'b0;
   logic [KIND_W-1:0] drive_kind = KIND_END;
   int                idle_pct = 0;
   int                stall_pct = 0;
   int                hold_len = 0;
   int                fail_count = 0;

   function automatic logic digit_char(input byte_t b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic logic name_char(input byte_t b);
      return digit_char(b) || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") ||
             b == "_" || b == ".";
   endfunction

   function automatic byte_t upcase(input byte_t b);
      return (b >= "a" && b <= "z") ? b - 8'd32 : b;
   endfunction

   function automatic void emit_beat(input logic [KIND_W-1:0] kind, input byte_t ch,
                                     input int idx, input logic empty, input logic last);
      beat_t bt;
      bt.kind  = kind;
      bt.ch    = ch;
      bt.idx   = INDEX_W'(idx);
      bt.empty = empty;
      bt.last  = last;
      lex_out.push_back(bt);
   endfunction

   function automatic void emit_char(input logic [KIND_W-1:0] kind, input byte_t ch);
      emit_beat(kind, ch, 0, 1'b0, 1'b1);
   endfunction

   function automatic void emit_pair(input logic [KIND_W-1:0] kind, input byte_t a,
                                     input byte_t b);
      emit_beat(kind, a, 0, 1'b0, 1'b0);
      emit_beat(kind, b, 1, 1'b0, 1'b1);
   endfunction

   function automatic void keep_char(input byte_t b);
      if (lex_len < TEXT_CAP - 1) begin
         lex_text[lex_len] = b;
         lex_len++;
      end
   endfunction

   function automatic void flush_text(input logic [KIND_W-1:0] kind);
      if (lex_len == 0) begin
         emit_beat(kind, CH_NUL, 0, 1'b1, 1'b1);
      end else begin
         for (int i = 0; i < lex_len; i++) begin
            emit_beat(kind, lex_text[i], i, 1'b0, i == lex_len - 1);
         end
      end
      lex_len  = 0;
      lex_mode = MODE_IDLE;
   endfunction

   function automatic logic [KIND_W-1:0] word_kind();
      logic hit;
      for (int k = 0; k < NUM_KW; k++) begin
         if (kw_names[k].len() == lex_len) begin
            hit = 1'b1;
            for (int i = 0; i < lex_len; i++) begin
               if (upcase(lex_text[i]) != byte_t'(kw_names[k][i])) begin
                  hit = 1'b0;
               end
            end
            if (hit) begin
               return KIND_KW0 + KIND_W'(k);
            end
         end
      end
      return KIND_IDENT;
   endfunction

   function automatic void lex_start(input byte_t b);
      lex_mode = MODE_IDLE;
      case (b)
         CH_SPACE, CH_TAB, CH_LF, CH_CR: ;
         CH_NUL:    emit_beat(KIND_END, CH_NUL, 0, 1'b1, 1'b1);
         CH_COMMA:  emit_char(KIND_COMMA, b);
         CH_STAR:   emit_char(KIND_STAR, b);
         CH_LPAREN: emit_char(KIND_LPAREN, b);
         CH_RPAREN: emit_char(KIND_RPAREN, b);
         CH_EQ:     emit_char(KIND_EQ, b);
         CH_BANG:   lex_mode = MODE_BANG;
         CH_LT:     lex_mode = MODE_LT;
         CH_GT:     lex_mode = MODE_GT;
         CH_MINUS:  lex_mode = MODE_MINUS;
         CH_SQUOTE, CH_DQUOTE: begin
            lex_dq   = (b == CH_DQUOTE);
            lex_len  = 0;
            lex_mode = MODE_STRING;
         end
         default: begin
            if (digit_char(b)) begin
               lex_len = 0;
               keep_char(b);
               lex_mode = MODE_NUMBER;
            end else if (name_char(b)) begin
               lex_len = 0;
               keep_char(b);
               lex_mode = MODE_IDENT;
            end else begin
               emit_char(KIND_ILLEGAL, b);
            end
         end
      endcase
   endfunction

   function automatic void lex_step(input byte_t b);
      case (lex_mode)
         MODE_IDENT: begin
            if (name_char(b)) begin
               keep_char(b);
            end else begin
               flush_text(word_kind());
               lex_start(b);
            end
         end
         MODE_NUMBER: begin
            if (digit_char(b)) begin
               keep_char(b);
            end else begin
               flush_text(KIND_NUMBER);
               lex_start(b);
            end
         end
         MODE_STRING: begin
            if (b == CH_NUL) begin
               flush_text(KIND_STRING);
               emit_beat(KIND_END, CH_NUL, 0, 1'b1, 1'b1);
            end else if (b == (lex_dq ? CH_DQUOTE : CH_SQUOTE)) begin
               flush_text(KIND_STRING);
            end else begin
               keep_char(b);
            end
         end
         MODE_MINUS: begin
            if (digit_char(b)) begin
               lex_len = 0;
               keep_char(CH_MINUS);
               keep_char(b);
               lex_mode = MODE_NUMBER;
            end else begin
               emit_char(KIND_ILLEGAL, CH_MINUS);
               lex_start(b);
            end
         end
         MODE_BANG: begin
            if (b == CH_EQ) begin
               emit_pair(KIND_NE, CH_BANG, CH_EQ);
               lex_mode = MODE_IDLE;
            end else begin
               emit_char(KIND_ILLEGAL, CH_BANG);
               lex_start(b);
            end
         end
         MODE_LT: begin
            if (b == CH_EQ) begin
               emit_pair(KIND_LE, CH_LT, CH_EQ);
               lex_mode = MODE_IDLE;
            end else begin
               emit_char(KIND_LT, CH_LT);
               lex_start(b);
            end
         end
         MODE_GT: begin
            if (b == CH_EQ) begin
               emit_pair(KIND_GE, CH_GT, CH_EQ);
               lex_mode = MODE_IDLE;
            end else begin
               emit_char(KIND_GT, CH_GT);
               lex_start(b);
            end
         end
         default: lex_start(b);
      endcase
   endfunction

   function automatic string beat_text(input beat_t bt);
      return $sformatf("kind %0d char %h index %0d empty %b last %b",
                       bt.kind, bt.ch, bt.idx, bt.empty, bt.last);
   endfunction

   task automatic report_mismatch(input string msg);
      fail_count++;
      if (fail_count <= MAX_LINES) begin
         $display("MISMATCH at %0t: %s", $realtime, msg);
      end
   endtask

   always @(posedge clock) begin : lex_watch
      beat_t got;
      beat_t want;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            got.kind  = rsp_if.token_kind;
            got.ch    = rsp_if.text_char;
            got.idx   = rsp_if.char_index;
            got.empty = rsp_if.text_empty;
            got.last  = rsp_if.token_last;
            if (beats_due.size() == 0) begin
               report_mismatch({"unexpected result: ", beat_text(got)});
            end else begin
               want = beats_due.pop_front();
               if (got !== want) begin
                  report_mismatch({"got ", beat_text(got), ", want ", beat_text(want)});
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            lex_out.delete();
            lex_step(req_if.in_byte);
            if (drive_typed) begin
               lex_out.delete();
               emit_beat(drive_kind, (drive_kind == KIND_END) ? CH_NUL : req_if.in_byte, 0,
                         drive_kind == KIND_END, 1'b1);
            end
            foreach (lex_out[i]) begin
               beats_due.push_back(lex_out[i]);
            end
         end
      end
   end

   always @(negedge clock) begin
      if (hold_len > 0) begin
         rsp_if.ready <= 1'b0;
         hold_len = hold_len - 1;
      end else begin
         rsp_if.ready <= (int'($urandom_range(99)) >= stall_pct);
      end
   end

   task automatic send_byte(input byte_t b, input logic typed, input logic [KIND_W-1:0] kind);
      while (int'($urandom_range(99)) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.in_byte <= b;
      drive_typed    <= typed;
      drive_kind     <= kind;
      @(posedge clock);
      while (!req_if.ready) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (beats_due.size() != 0) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   function automatic byte_t rand_name_char();
      int pick;
      pick = $urandom_range(63);
      if (pick < 26) begin
         return byte_t'("A" + pick);
      end else if (pick < 52) begin
         return byte_t'("a" + pick - 26);
      end else if (pick < 62) begin
         return byte_t'("0" + pick - 52);
      end
      return (pick == 62) ? byte_t'("_") : byte_t'(".");
   endfunction

   function automatic byte_t rand_text_char(input byte_t quote);
      byte_t b;
      do begin
         b = byte_t'($urandom_range(1, 255));
      end while (b == quote);
      return b;
   endfunction

   task automatic add_statement(ref byte_t q [$], input logic with_long);
      int    n_tok;
      int    pick;
      int    len;
      byte_t quote;
      byte_t ch;
      string word;
      n_tok = $urandom_range(2, 6);
      if (with_long) begin
         q.push_back("L");
         for (int j = 0; j < TEXT_CAP + 1; j++) begin
            q.push_back(rand_name_char());
         end
         q.push_back(CH_SPACE);
         q.push_back(CH_SQUOTE);
         for (int j = 0; j < TEXT_CAP; j++) begin
            q.push_back(rand_text_char(CH_SQUOTE));
         end
         q.push_back(CH_SQUOTE);
      end
      for (int t = 0; t < n_tok; t++) begin
         pick = $urandom_range(99);
         if (pick < 18) begin
            word = kw_names[$urandom_range(NUM_KW - 1)];
            for (int j = 0; j < word.len(); j++) begin
               ch = byte_t'(word[j]);
               if ($urandom_range(1) == 1) begin
                  ch = ch + 8'd32;
               end
               q.push_back(ch);
            end
         end else if (pick < 33) begin
            len = $urandom_range(1, 6);
            for (int j = 0; j < len; j++) begin
               q.push_back(rand_name_char());
            end
         end else if (pick < 45) begin
            if ($urandom_range(3) == 0) begin
               q.push_back(CH_MINUS);
            end
            len = $urandom_range(1, 5);
            for (int j = 0; j < len; j++) begin
               q.push_back(byte_t'("0" + $urandom_range(9)));
            end
         end else if (pick < 57) begin
            quote = ($urandom_range(1) == 1) ? CH_DQUOTE : CH_SQUOTE;
            q.push_back(quote);
            len = $urandom_range(0, 6);
            for (int j = 0; j < len; j++) begin
               q.push_back(rand_text_char(quote));
            end
            if ($urandom_range(7) != 0) begin
               q.push_back(quote);
            end
         end else if (pick < 77) begin
            case ($urandom_range(11))
               0:  q.push_back(CH_COMMA);
               1:  q.push_back(CH_STAR);
               2:  q.push_back(CH_LPAREN);
               3:  q.push_back(CH_RPAREN);
               4:  q.push_back(CH_EQ);
               5:  begin q.push_back(CH_BANG); q.push_back(CH_EQ); end
               6:  begin q.push_back(CH_LT); q.push_back(CH_EQ); end
               7:  begin q.push_back(CH_GT); q.push_back(CH_EQ); end
               8:  q.push_back(CH_LT);
               9:  q.push_back(CH_GT);
               10: q.push_back(CH_BANG);
               default: q.push_back(CH_MINUS);
            endcase
         end else if (pick < 88) begin
            case ($urandom_range(3))
               0:       q.push_back(CH_SPACE);
               1:       q.push_back(CH_TAB);
               2:       q.push_back(CH_LF);
               default: q.push_back(CH_CR);
            endcase
         end else begin
            q.push_back(byte_t'($urandom_range(1, 255)));
         end
         if ($urandom_range(1) == 1) begin
            q.push_back(CH_SPACE);
         end
      end
      q.push_back(CH_NUL);
   endtask

   initial begin
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** sql_token_scanner_core: FAILED **");
      $finish;
   end

   initial begin
      byte_t stream [$];
      req_if.valid   = 1'b0;
      req_if.in_byte = '0;
      rsp_if.ready   = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (probe_rows[i]) begin
         send_byte(probe_rows[i].b, probe_rows[i].typed, probe_rows[i].kind);
      end
      drain();

      // The first phase stalls the result side for a long stretch so that the input backs up.
      for (int phase = 0; phase < 4; phase++) begin
         idle_pct  = (phase == 1) ? 51 : (phase == 3) ? 16 : 0;
         stall_pct = (phase == 2) ? 51 : (phase == 3) ? 16 : 0;
         if (phase == 0) begin
            hold_len = LONG_HOLD;
         end
         stream.delete();
         add_statement(stream, phase == 0);
         while (stream.size() < PHASE_BYTES) begin
            add_statement(stream, 1'b0);
         end
         foreach (stream[i]) begin
            send_byte(stream[i], 1'b0, KIND_END);
         end
         drain();
      end

      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0) begin
         $display("** sql_token_scanner_core: PASSED **");
      end else begin
         $display("** sql_token_scanner_core: FAILED **");
      end
      $finish;
   end

endmodule
